// ----- rtl/core/lrd_pkg.sv -----
package lrd_pkg;

    localparam int BYTE_W   = 8;
    localparam int CNT_W    = 32;
    localparam int LEN_W    = 32;
    localparam int OFS_W    = 24;
    localparam int TOTAL_W  = OFS_W + 1;

    // record framing
    localparam int SYNC_LEN  = 4;
    localparam int LEN_POS   = 16;
    localparam int HDR_LEN   = 20;
    localparam int CHECK_LEN = 4;

    localparam logic [TOTAL_W-1:0] BUFFER_BYTES = TOTAL_W'(1) << OFS_W;

    localparam logic [BYTE_W-1:0] SYNC_WORD [SYNC_LEN] = '{8'h4C, 8'h44, 8'h53, 8'h58};

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [BYTE_W-1:0]  payload_byte;
        logic [OFS_W-1:0]   buffer_offset;
        logic               last_in_record;
        logic [TOTAL_W-1:0] total_bytes;
        logic               overflow;
    } res_t;

endpackage

// ----- rtl/core/lrd_parser.sv -----
module lrd_parser
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_take,
    input  logic [lrd_pkg::BYTE_W-1:0]  stream_byte,
    input  logic                        cfg_take,
    input  logic [lrd_pkg::OFS_W-1:0]   cfg_data,
    output logic                        res_valid,
    output lrd_pkg::res_t               res
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_CHECK,
        PH_ENDED
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [lrd_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [lrd_pkg::LEN_W-1:0]       len_reg, len_next;
    logic [lrd_pkg::TOTAL_W-1:0]     wofs_reg, wofs_next;
    logic                            ovf_reg, ovf_next;

    logic [lrd_pkg::CNT_W:0]         cnt_inc;
    logic                            last;

    assign cnt_inc = {1'b0, cnt_reg} + (lrd_pkg::CNT_W+1)'(1);
    assign last    = cnt_inc >= {1'b0, len_reg};

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        wofs_next  = wofs_reg;
        ovf_next   = ovf_reg;
        res_valid  = 1'b0;
        res        = '0;

        if (in_take)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (cnt_reg < lrd_pkg::CNT_W'(lrd_pkg::SYNC_LEN))
                    begin
                        if (stream_byte != lrd_pkg::SYNC_WORD[cnt_reg[1:0]])
                        begin
                            phase_next      = PH_ENDED;
                            res_valid       = 1'b1;
                            res.kind        = lrd_pkg::KIND_END;
                            res.total_bytes = wofs_reg;
                            res.overflow    = ovf_reg;
                        end
                        else
                        begin
                            cnt_next = cnt_inc[lrd_pkg::CNT_W-1:0];
                        end
                    end
                    else
                    begin
                        // length bytes shift in from the top, little-endian
                        if (cnt_reg >= lrd_pkg::CNT_W'(lrd_pkg::LEN_POS))
                        begin
                            len_next = {stream_byte, len_reg[lrd_pkg::LEN_W-1:lrd_pkg::BYTE_W]};
                        end
                        if (cnt_reg == lrd_pkg::CNT_W'(lrd_pkg::HDR_LEN - 1))
                        begin
                            cnt_next   = '0;
                            phase_next = (len_next == '0) ? PH_CHECK : PH_PAYLOAD;
                        end
                        else
                        begin
                            cnt_next = cnt_inc[lrd_pkg::CNT_W-1:0];
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    if (wofs_reg < lrd_pkg::BUFFER_BYTES)
                    begin
                        res_valid          = 1'b1;
                        res.kind           = lrd_pkg::KIND_PAYLOAD;
                        res.payload_byte   = stream_byte;
                        res.buffer_offset  = wofs_reg[lrd_pkg::OFS_W-1:0];
                        res.last_in_record = last;
                        res.overflow       = ovf_reg;
                        wofs_next          = wofs_reg + lrd_pkg::TOTAL_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        cnt_next   = '0;
                        phase_next = PH_CHECK;
                    end
                    else
                    begin
                        cnt_next = cnt_inc[lrd_pkg::CNT_W-1:0];
                    end
                end
                PH_CHECK:
                begin
                    // trailing check bytes are skipped unverified
                    if (cnt_reg == lrd_pkg::CNT_W'(lrd_pkg::CHECK_LEN - 1))
                    begin
                        cnt_next   = '0;
                        phase_next = PH_HEADER;
                    end
                    else
                    begin
                        cnt_next = cnt_inc[lrd_pkg::CNT_W-1:0];
                    end
                end
                PH_ENDED:
                begin
                    // stream is over until reset
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (cfg_take)
        begin
            wofs_next = {1'b0, cfg_data};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            cnt_reg   <= '0;
            len_reg   <= '0;
            wofs_reg  <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            wofs_reg  <= wofs_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// ----- rtl/core/lrd_out_reg.sv -----
module lrd_out_reg
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           res_valid,
    input  lrd_pkg::res_t  res,
    output logic           load_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output lrd_pkg::res_t  out_res
);

    logic           valid_reg, valid_next;
    lrd_pkg::res_t  res_reg, res_next;

    // free slot or the held transaction leaves this cycle
    assign load_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (load_ready)
        begin
            valid_next = res_valid;
            res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ----- rtl/core/log_record_deframer_top.sv -----
// Log record deframer: takes a stored log stream one byte per transaction and emits each
// payload byte with its buffer offset and a last-in-record mark. Records are a 20-byte header
// (4-byte sync word, 12 ignored bytes, 32-bit little-endian payload length), the payload, and
// 4 check bytes that are skipped. A sync mismatch yields one end result (kind 1) carrying the
// total offset, after which bytes are swallowed until reset. Bytes landing at or beyond the
// 16 MiB buffer are dropped and set the sticky overflow flag. One byte is accepted per cycle
// while in_ready is high; results pass through the result register, and in_ready drops only
// while that register holds a result that out_ready has not taken. Writing cfg_data (start
// offset) also reloads the running write offset and is meant for idle periods only.
module log_record_deframer_top
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lrd_pkg::OFS_W-1:0]   cfg_data,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [lrd_pkg::BYTE_W-1:0]  stream_byte,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        kind,
    output logic [lrd_pkg::BYTE_W-1:0]  payload_byte,
    output logic [lrd_pkg::OFS_W-1:0]   buffer_offset,
    output logic                        last_in_record,
    output logic [lrd_pkg::TOTAL_W-1:0] total_bytes,
    output logic                        overflow
);

    logic           in_take;
    logic           cfg_take;
    logic           res_valid;
    lrd_pkg::res_t  res;
    lrd_pkg::res_t  out_res;
    logic           load_ready;

    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign in_ready  = load_ready;
    assign in_take   = in_valid && in_ready;

    lrd_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_take     (in_take),
        .stream_byte (stream_byte),
        .cfg_take    (cfg_take),
        .cfg_data    (cfg_data),
        .res_valid   (res_valid),
        .res         (res)
    );

    lrd_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res        (res),
        .load_ready (load_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_res    (out_res)
    );

    assign kind           = out_res.kind;
    assign payload_byte   = out_res.payload_byte;
    assign buffer_offset  = out_res.buffer_offset;
    assign last_in_record = out_res.last_in_record;
    assign total_bytes    = out_res.total_bytes;
    assign overflow       = out_res.overflow;

endmodule
